### hdl/ultrasonic_range_proximity_led_top_macros.svh
// Assertion macros shared by the checker of the ultrasonic ranging block.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ULTRASONIC_RANGE_PROXIMITY_LED_TOP_MACROS_SVH
`define ULTRASONIC_RANGE_PROXIMITY_LED_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define URPL_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define URPL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/urpl_pkg.sv
// Shared types and constants of the ultrasonic ranging block.
// No dependencies; used by the top, urpl_in_reg, urpl_core, urpl_out_reg and the testbench.
package urpl_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CfgIntervalIdx = 2'd0;
  localparam logic [1:0] CfgHoldIdx     = 2'd1;
  localparam logic [1:0] CfgNearIdx     = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [15:0] IntervalRst = 16'd100;
  localparam logic [15:0] HoldRst     = 16'd5000;
  localparam logic [15:0] NearRst     = 16'd30;

  // Distance reported when no echo width was captured.
  localparam logic [15:0] FailCm = 16'hFFFF;

  // floor(w*17/250) equals floor(w*CmRecip / 2^CmShift) for every 16-bit w.
  localparam int unsigned  CmShift = 24;
  localparam logic [20:0]  CmRecip = 21'd1140851;

  // Action codes.
  localparam logic ActEcho = 1'b0;
  localparam logic ActTime = 1'b1;

  typedef struct packed {
    logic        action;
    logic        echo_level;
    logic [15:0] timer_count;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic        trigger_fired;
    logic [15:0] distance_cm;
    logic        led_lit;
    logic [15:0] pulse_ticks;
  } result_t;

endpackage

### hdl/urpl_evt_if.sv
// Input event channel of the ultrasonic ranging block.
// No dependencies.
interface urpl_evt_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic        echo_level;
  logic [15:0] timer_count;
  logic [31:0] now_ms;

  modport source (output valid, action, echo_level, timer_count, now_ms, input ready);
  modport sink   (input valid, action, echo_level, timer_count, now_ms, output ready);
endinterface

### hdl/urpl_res_if.sv
// Result channel of the ultrasonic ranging block.
// No dependencies.
interface urpl_res_if;
  logic        valid;
  logic        ready;
  logic        trigger_fired;
  logic [15:0] distance_cm;
  logic        led_lit;
  logic [15:0] pulse_ticks;

  modport source (output valid, trigger_fired, distance_cm, led_lit, pulse_ticks, input ready);
  modport sink   (input valid, trigger_fired, distance_cm, led_lit, pulse_ticks, output ready);
endinterface

### hdl/ultrasonic_range_proximity_led_top.sv
// Channel  | Dir | Beat contents
// evt_i    | in  | action, echo_level, timer_count, now_ms
// res_o    | out | trigger_fired, distance_cm, led_lit, pulse_ticks
// cfg_*    | in  | register index and 16-bit data, one write per cycle
//
// One event per cycle unless a stalled result fills the input register; each result
// beat is computed in the core from the input register and presented from the result register.
// The per-event state update sits between the input and result registers.
// Reset brings all state to zero and the configuration registers to their defaults.
// A stalled result holds the pipeline; the input register still takes one beat.
// Depends on urpl_pkg, urpl_evt_if, urpl_res_if and the three stage modules.
module ultrasonic_range_proximity_led_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  urpl_evt_if.sink    evt_i,
  urpl_res_if.source  res_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  urpl_pkg::item_t   in_item;
  urpl_pkg::item_t   stage_item;
  urpl_pkg::result_t core_res;
  urpl_pkg::result_t out_res;
  logic              stage_valid;
  logic              take;
  logic              fire;
  logic              in_ready;
  logic              out_valid;

  assign in_item.action      = evt_i.action;
  assign in_item.echo_level  = evt_i.echo_level;
  assign in_item.timer_count = evt_i.timer_count;
  assign in_item.now_ms      = evt_i.now_ms;
  assign evt_i.ready         = in_ready;

  // An event updates the state exactly when its result enters the output stage.
  assign fire = stage_valid && take;

  urpl_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (evt_i.valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .take_i     (take),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  urpl_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .item_i     (stage_item),
    .res_o      (core_res)
  );

  urpl_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stage_valid),
    .res_i       (core_res),
    .take_o      (take),
    .out_valid_o (out_valid),
    .out_ready_i (res_o.ready),
    .out_res_o   (out_res)
  );

  assign res_o.valid         = out_valid;
  assign res_o.trigger_fired = out_res.trigger_fired;
  assign res_o.distance_cm   = out_res.distance_cm;
  assign res_o.led_lit       = out_res.led_lit;
  assign res_o.pulse_ticks   = out_res.pulse_ticks;

endmodule

### hdl/urpl_in_reg.sv
// Input register stage: holds one accepted event beat for the core.
// Depends on urpl_pkg.
module urpl_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  urpl_pkg::item_t in_item_i,
  input  logic            take_i,
  output logic            valid_o,
  output urpl_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  urpl_pkg::item_t item_q;

  // The stage is free when empty or when its beat moves on this cycle.
  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### hdl/urpl_core.sv
// Ranging core: configuration and measurement state, and the per-event update.
// Depends on urpl_pkg.
module urpl_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              fire_i,
  input  urpl_pkg::item_t   item_i,
  output urpl_pkg::result_t res_o
);

  logic [15:0] interval_q, hold_q, near_q;
  logic [15:0] start_q, start_d;
  logic [15:0] width_q, width_d;
  logic [31:0] last_q, last_d;
  logic [31:0] led_start_q, led_start_d;
  logic        hold_act_q, hold_act_d;
  logic        led_q, led_d;

  logic [36:0] cm_prod;
  logic [15:0] cm;
  logic [31:0] since_trig;
  logic [31:0] since_led;
  logic        trig;
  logic        near_hit;
  logic        hold_done;
  logic [15:0] dist_cm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= urpl_pkg::IntervalRst;
      hold_q     <= urpl_pkg::HoldRst;
      near_q     <= urpl_pkg::NearRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        urpl_pkg::CfgIntervalIdx: interval_q <= cfg_data_i;
        urpl_pkg::CfgHoldIdx:     hold_q     <= cfg_data_i;
        urpl_pkg::CfgNearIdx:     near_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Distance from the stored width: floor(width*136/1000)/2 by reciprocal.
  assign cm_prod = {21'd0, width_q} * {16'd0, urpl_pkg::CmRecip};
  assign cm      = {3'd0, cm_prod[36:urpl_pkg::CmShift]};

  assign since_trig = item_i.now_ms - last_q;
  assign since_led  = item_i.now_ms - led_start_q;
  assign trig       = (item_i.action == urpl_pkg::ActTime) &&
                      (since_trig >= {16'd0, interval_q});
  assign near_hit   = trig && (width_q != 16'd0) && (cm < near_q);

  // A fresh near hit restarts the hold at now, so it expires at once only
  // for a zero hold time.
  assign hold_done = near_hit ? (hold_q == 16'd0)
                              : (hold_act_q && (since_led >= {16'd0, hold_q}));

  always_comb begin
    start_d     = start_q;
    width_d     = width_q;
    last_d      = last_q;
    led_start_d = led_start_q;
    hold_act_d  = hold_act_q;
    led_d       = led_q;
    dist_cm     = 16'd0;
    if (item_i.action == urpl_pkg::ActEcho) begin
      if (item_i.echo_level) begin
        start_d = item_i.timer_count;
      end else begin
        width_d = item_i.timer_count - start_q;
      end
    end else begin
      if (trig) begin
        last_d = item_i.now_ms;
        if (width_q == 16'd0) begin
          dist_cm = urpl_pkg::FailCm;
          led_d   = 1'b0;
        end else begin
          dist_cm = cm;
        end
      end
      if (near_hit) begin
        led_d       = 1'b1;
        hold_act_d  = 1'b1;
        led_start_d = item_i.now_ms;
      end
      if (hold_done) begin
        led_d      = 1'b0;
        hold_act_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= '0;
      width_q     <= '0;
      last_q      <= '0;
      led_start_q <= '0;
      hold_act_q  <= 1'b0;
      led_q       <= 1'b0;
    end else if (fire_i) begin
      start_q     <= start_d;
      width_q     <= width_d;
      last_q      <= last_d;
      led_start_q <= led_start_d;
      hold_act_q  <= hold_act_d;
      led_q       <= led_d;
    end
  end

  assign res_o.trigger_fired = trig;
  assign res_o.distance_cm   = dist_cm;
  assign res_o.led_lit       = led_d;
  assign res_o.pulse_ticks   = width_d;

endmodule

### hdl/urpl_out_reg.sv
// Result register stage: holds one result beat until the sink takes it.
// Depends on urpl_pkg.
module urpl_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  urpl_pkg::result_t res_i,
  output logic              take_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output urpl_pkg::result_t out_res_o
);

  logic              valid_q, valid_d;
  urpl_pkg::result_t res_q;

  // The register can load when empty or when its beat leaves this cycle.
  assign take_o  = !valid_q || out_ready_i;
  assign valid_d = take_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule

### hdl/urpl_checker.sv
// Port-level checker of the ultrasonic ranging block and its bind.
// Depends on ultrasonic_range_proximity_led_top_macros.svh.
`include "ultrasonic_range_proximity_led_top_macros.svh"

module urpl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic        res_trigger_i,
  input logic [15:0] res_dist_i,
  input logic        res_led_i,
  input logic [15:0] res_ticks_i
);

  logic stall;
  assign stall = res_valid_i && !res_ready_i;

  `URPL_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, stall, res_valid_i, "result beat dropped while stalled")
  `URPL_ASSERT_NEXT(a_res_stable, clk_i, rst_ni, stall, $stable(res_dist_i) && $stable(res_ticks_i) && $stable(res_led_i) && $stable(res_trigger_i), "result payload changed while stalled")
  `URPL_ASSERT_NOW(a_no_trig_dist, clk_i, rst_ni, res_valid_i && !res_trigger_i, res_dist_i == 16'd0, "distance reported without a trigger")
  `URPL_ASSERT_NOW(a_fail_led_off, clk_i, rst_ni, res_valid_i && res_trigger_i && (res_dist_i == 16'hFFFF), !res_led_i, "LED lit after a failed measurement")
  `URPL_ASSERT_NOW(a_dist_range, clk_i, rst_ni, res_valid_i && res_trigger_i, (res_dist_i == 16'hFFFF) || (res_dist_i <= 16'd4456), "distance out of range")

endmodule

bind ultrasonic_range_proximity_led_top urpl_checker u_urpl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_trigger_i (res_o.trigger_fired),
  .res_dist_i    (res_o.distance_cm),
  .res_led_i     (res_o.led_lit),
  .res_ticks_i   (res_o.pulse_ticks)
);

### test/tb_ultrasonic_range_proximity_led_top.sv
// Self-checking testbench for the ultrasonic ranging block with proximity LED.
// Drives echo-edge and time beats, predicts each result in-bench and compares.
// Depends on urpl_pkg, urpl_evt_if, urpl_res_if and ultrasonic_range_proximity_led_top.
module tb_ultrasonic_range_proximity_led_top;

  localparam logic [1:0] CfgSpareIdx = 2'd3;
  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned PhaseItems = 210;

  typedef enum logic [1:0] {FlowFree, FlowSrcIdle, FlowSnkStall, FlowBothIdle} flow_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  urpl_evt_if evt_if ();
  urpl_res_if res_if ();

  ultrasonic_range_proximity_led_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .evt_i      (evt_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted block state and register copies.
  logic [15:0] cfg_interval, cfg_hold, cfg_near;
  logic [15:0] echo_start, echo_width;
  logic [31:0] last_fire_ms, hold_from_ms;
  logic        hold_on, led_on;

  urpl_pkg::item_t   evt_queue[$];
  urpl_pkg::result_t range_expect_q[$];
  urpl_pkg::item_t   next_evt;
  logic        evt_fire = 1'b0;
  logic [31:0] wall_ms;
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_events = 0, n_results = 0, n_fired = 0, n_lit = 0, n_fail_cm = 0;
  int unsigned n_errors = 0;

  function automatic urpl_pkg::result_t range_step(urpl_pkg::item_t it);
    urpl_pkg::result_t r;
    logic [31:0] elapsed;
    logic [31:0] held;
    logic [15:0] cm;
    r = '0;
    if (it.action == urpl_pkg::ActEcho) begin
      if (it.echo_level) echo_start = it.timer_count;
      else echo_width = it.timer_count - echo_start;
    end else begin
      elapsed = it.now_ms - last_fire_ms;
      if (elapsed >= {16'd0, cfg_interval}) begin
        r.trigger_fired = 1'b1;
        if (echo_width == '0) begin
          r.distance_cm = urpl_pkg::FailCm;
          led_on = 1'b0;
        end else begin
          // Round trip at 34000 cm/s with 4 us ticks: width * 0.136 / 2.
          cm = 16'(((32'(echo_width) * 32'd136) / 32'd1000) / 32'd2);
          r.distance_cm = cm;
          if (cm < cfg_near) begin
            led_on = 1'b1;
            hold_on = 1'b1;
            hold_from_ms = it.now_ms;
          end
        end
        last_fire_ms = it.now_ms;
      end
      // The hold check follows the trigger, so a zero hold clears a fresh hit.
      held = it.now_ms - hold_from_ms;
      if (hold_on && held >= {16'd0, cfg_hold}) begin
        led_on = 1'b0;
        hold_on = 1'b0;
      end
    end
    r.led_lit = led_on;
    r.pulse_ticks = echo_width;
    return r;
  endfunction

  task automatic queue_evt(logic act, logic lvl, logic [15:0] cnt, logic [31:0] ms);
    urpl_pkg::item_t it;
    it.action = act;
    it.echo_level = lvl;
    it.timer_count = cnt;
    it.now_ms = ms;
    evt_queue.push_back(it);
  endtask

  // Fields that an event ignores are filled with noise.
  task automatic queue_edge(logic lvl, logic [15:0] cnt);
    queue_evt(urpl_pkg::ActEcho, lvl, cnt, $urandom);
  endtask

  task automatic queue_time(logic [31:0] ms);
    queue_evt(urpl_pkg::ActTime, 1'($urandom), 16'($urandom), ms);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    case (idx)
      urpl_pkg::CfgIntervalIdx: cfg_interval = val;
      urpl_pkg::CfgHoldIdx:     cfg_hold = val;
      urpl_pkg::CfgNearIdx:     cfg_near = val;
      default:        ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Mostly full measurements (rise, fall, then time beats), plus broken edges and noise.
  task automatic make_traffic(int unsigned n);
    int unsigned made;
    int unsigned r;
    int unsigned wmax;
    logic [15:0] c0, w;
    logic [31:0] span;
    made = 0;
    while (made < n) begin
      r = $urandom_range(99);
      if (r < 75) begin
        c0 = 16'($urandom);
        wmax = (cfg_near > 2000) ? 65535 : cfg_near * 30 + 100;
        if ($urandom_range(7) == 0) w = '0;
        else if ($urandom_range(9) == 0) w = 16'($urandom);
        else w = 16'($urandom_range(1, wmax));
        queue_edge(1'b1, c0);
        queue_edge(1'b0, c0 + w);
        made += 2;
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(9) == 0) span = {15'd0, cfg_hold, 1'b0} + 32'd2;
          else span = {15'd0, cfg_interval, 1'b0} + 32'd2;
          wall_ms += $urandom_range(0, span);
          queue_time(wall_ms);
          made++;
        end
      end else if (r < 85) begin
        queue_edge(1'($urandom), 16'($urandom));
        made++;
      end else if (r < 88) begin
        wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
      end else begin
        queue_evt(1'($urandom), 1'($urandom), 16'($urandom), $urandom);
        made++;
      end
    end
  endtask

  task automatic drain;
    while (evt_queue.size() != 0 || evt_if.valid || range_expect_q.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Event driver: holds a beat until it is taken, then may idle.
  always @(negedge clk_i) begin
    if (rst_ni && (!evt_if.valid || evt_fire)) begin
      if (evt_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        next_evt = evt_queue.pop_front();
        evt_if.valid <= 1'b1;
        evt_if.action <= next_evt.action;
        evt_if.echo_level <= next_evt.echo_level;
        evt_if.timer_count <= next_evt.timer_count;
        evt_if.now_ms <= next_evt.now_ms;
      end else begin
        evt_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Monitor: predicts on each event beat and checks each result beat.
  always @(posedge clk_i) begin
    urpl_pkg::item_t   acc;
    urpl_pkg::result_t exp_r;
    evt_fire = 1'b0;
    if (rst_ni) begin
      if (evt_if.valid && evt_if.ready) begin
        evt_fire = 1'b1;
        acc = {evt_if.action, evt_if.echo_level, evt_if.timer_count, evt_if.now_ms};
        range_expect_q.push_back(range_step(acc));
        n_events++;
      end
      if (res_if.valid && res_if.ready) begin
        n_results++;
        if (res_if.trigger_fired) n_fired++;
        if (res_if.led_lit) n_lit++;
        if (res_if.trigger_fired && res_if.distance_cm == urpl_pkg::FailCm) n_fail_cm++;
        if (range_expect_q.size() == 0) begin
          $error("result beat with nothing expected");
          n_errors++;
        end else begin
          exp_r = range_expect_q.pop_front();
          if (res_if.trigger_fired !== exp_r.trigger_fired) begin
            $error("trigger_fired: expected %0d, got %0d", exp_r.trigger_fired,
                   res_if.trigger_fired);
            n_errors++;
          end
          if (res_if.distance_cm !== exp_r.distance_cm) begin
            $error("distance_cm: expected %0d, got %0d", exp_r.distance_cm,
                   res_if.distance_cm);
            n_errors++;
          end
          if (res_if.led_lit !== exp_r.led_lit) begin
            $error("led_lit: expected %0d, got %0d", exp_r.led_lit, res_if.led_lit);
            n_errors++;
          end
          if (res_if.pulse_ticks !== exp_r.pulse_ticks) begin
            $error("pulse_ticks: expected %0d, got %0d", exp_r.pulse_ticks,
                   res_if.pulse_ticks);
            n_errors++;
          end
        end
      end
      if (evt_fire || (res_if.valid && res_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("watchdog: no beat for %0d cycles", QuietLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] ival, hval, nval;
    flow_e       flow;
    evt_if.valid = 1'b0;
    evt_if.action = urpl_pkg::ActEcho;
    evt_if.echo_level = 1'b0;
    evt_if.timer_count = '0;
    evt_if.now_ms = '0;
    res_if.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = urpl_pkg::CfgIntervalIdx;
    cfg_data_i = '0;
    cfg_interval = urpl_pkg::IntervalRst;
    cfg_hold = urpl_pkg::HoldRst;
    cfg_near = urpl_pkg::NearRst;
    echo_start = '0;
    echo_width = '0;
    last_fire_ms = '0;
    hold_from_ms = '0;
    hold_on = 1'b0;
    led_on = 1'b0;
    wall_ms = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part under the reset settings.
    queue_time(32'd0);                 // interval not yet elapsed
    queue_time(32'd100);               // trigger with no width captured
    queue_edge(1'b1, 16'hFFF0);
    queue_edge(1'b0, 16'h0010);        // width wraps through zero
    queue_time(32'd150);
    queue_time(32'd200);               // near hit starts the hold
    queue_edge(1'b1, 16'h0000);
    queue_edge(1'b0, 16'hFFFF);        // widest pulse, farthest distance
    queue_time(32'd300);
    queue_time(32'd5199);
    queue_time(32'd5200);              // hold runs out
    queue_edge(1'b1, 16'd100);
    queue_edge(1'b0, 16'd200);
    queue_time(32'd5300);
    queue_edge(1'b1, 16'h1234);
    queue_edge(1'b0, 16'h1234);        // zero width while lit
    queue_time(32'd5400);
    queue_time(32'd10300);
    queue_time(32'hFFFF_FFFF);
    queue_time(32'd50);                // time wraps past 2^32
    queue_time(32'd99);
    queue_evt(urpl_pkg::ActEcho, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
    queue_evt(urpl_pkg::ActTime, 1'b1, 16'hFFFF, 32'd400);
    wall_ms = 32'd400;
    drain();

    for (int p = 1; p <= 7; p++) begin
      case (p)
        1: begin ival = 16'd0;    hval = 16'd0;    nval = 16'hFFFF; flow = FlowSrcIdle; end
        2: begin ival = 16'hFFFF; hval = 16'hFFFF; nval = 16'd0;    flow = FlowSnkStall; end
        3: begin ival = 16'd20;   hval = 16'd300;  nval = 16'd1000; flow = FlowBothIdle; end
        4: begin
          ival = 16'($urandom_range(0, 300));
          hval = 16'($urandom_range(0, 3000));
          nval = 16'($urandom_range(0, 600));
          flow = FlowFree;
        end
        5: begin
          ival = urpl_pkg::IntervalRst;
          hval = urpl_pkg::HoldRst;
          nval = urpl_pkg::NearRst;
          flow = FlowSrcIdle;
        end
        6: begin ival = 16'd1;    hval = 16'd1;    nval = 16'd1;    flow = FlowSnkStall; end
        default: begin
          ival = 16'($urandom_range(0, 150));
          hval = 16'($urandom_range(0, 800));
          nval = 16'($urandom_range(0, 4500));
          flow = FlowBothIdle;
        end
      endcase
      write_cfg(urpl_pkg::CfgIntervalIdx, ival);
      write_cfg(urpl_pkg::CfgHoldIdx, hval);
      write_cfg(urpl_pkg::CfgNearIdx, nval);
      if (p == 5) write_cfg(CfgSpareIdx, 16'($urandom));
      src_idle_pct = (flow == FlowSrcIdle) ? 61 : (flow == FlowBothIdle) ? 13 : 0;
      snk_stall_pct = (flow == FlowSnkStall) ? 61 : (flow == FlowBothIdle) ? 13 : 0;
      make_traffic(PhaseItems);
      drain();
    end

    repeat (8) @(negedge clk_i);
    if (range_expect_q.size() != 0) begin
      $error("%0d expected results never arrived", range_expect_q.size());
      n_errors++;
    end
    $display("Covered %0d event beats and %0d result beats over 8 settings phases;",
             n_events, n_results);
    $display("%0d triggers, %0d with no echo width, %0d results with the LED lit.",
             n_fired, n_fail_cm, n_lit);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### ultrasonic_range_proximity_led_top.f
+incdir+hdl
hdl/urpl_pkg.sv
hdl/urpl_evt_if.sv
hdl/urpl_res_if.sv
hdl/urpl_in_reg.sv
hdl/urpl_core.sv
hdl/urpl_out_reg.sv
hdl/ultrasonic_range_proximity_led_top.sv
hdl/urpl_checker.sv
test/tb_ultrasonic_range_proximity_led_top.sv
